// ===== rtl/core/pidtr_pkg.sv =====
// shared types and constants of the trapezoidal pid regulator
package pidtr_pkg;

   localparam int unsigned GAIN_FRAC_BITS = 8;

   localparam int unsigned DATA_W     = 16;
   localparam int unsigned LIMIT_W    = 15;
   localparam int unsigned ERR_W      = 17;
   localparam int unsigned DERIV_W    = 18;
   localparam int unsigned INTEG_W    = 19;
   localparam int unsigned DRIVE_W    = 27;
   localparam int unsigned ACC_W      = 38;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned RSP_DATA_W = 48;

   // bound on the integral magnitude in half-units; the largest reachable is 196603
   localparam int INTEG_BOUND = 196606;

   typedef enum logic [1:0] {
      KIND_SAMPLE      = 2'd0,
      KIND_CLEAR_ALL   = 2'd1,
      KIND_CLEAR_INTEG = 2'd2,
      KIND_NONE        = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT = 3'd0,
      CSR_GAIN_P   = 3'd1,
      CSR_GAIN_I   = 3'd2,
      CSR_GAIN_D   = 3'd3,
      CSR_LIMIT    = 3'd4
   } csr_index_type;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd50;

endpackage

// ===== rtl/core/pid_trapezoid_reset_integral.sv =====
// top level of the trapezoidal pid regulator with integral clearing
//
// Takes one item per cycle on req_ while the output is not stalled and returns one
// result per sample item on rsp_, through the input register, stage b and the output
// register. Clear items (clear integral and previous error, clear integral only)
// update state and return nothing; the unused kind neither updates state nor
// returns a result. The loop state (previous error, integral in half-units) is
// updated as an item leaves the input register, which sets the one-item-per-cycle
// rate; the three gain products and their sum sit in stage c, after stage b.
// Every stage has its own valid bit, so empty stages keep accepting while a result
// waits on rsp_tready. Write the csr_ registers only while the block is idle.
module pid_trapezoid_reset_integral
   import pidtr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [DATA_W-1:0]     csr_wdata,
   // items in
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,   // [15:0] process_value
   input  logic [1:0]            req_tuser,   // [1:0] kind
   // results out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [26:0] drive_value, [44:27] derivative
);

   // configuration registers
   logic signed [DATA_W-1:0] setpoint_ff;
   logic signed [DATA_W-1:0] gain_p_ff;
   logic signed [DATA_W-1:0] gain_i_ff;
   logic signed [DATA_W-1:0] gain_d_ff;
   logic [LIMIT_W-1:0]       limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= '0;
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
         limit_ff    <= LIMIT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SETPOINT: setpoint_ff <= csr_wdata;
            CSR_GAIN_P:   gain_p_ff   <= csr_wdata;
            CSR_GAIN_I:   gain_i_ff   <= csr_wdata;
            CSR_GAIN_D:   gain_d_ff   <= csr_wdata;
            CSR_LIMIT:    limit_ff    <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // stage handshake chain
   logic a_valid_ff, b_valid_ff, rsp_valid_ff;
   logic ready_out, ready_b, ready_a;
   logic a_xfer, b_xfer;

   assign ready_out  = !rsp_valid_ff || rsp_tready;
   assign ready_b    = !b_valid_ff || ready_out;
   assign ready_a    = !a_valid_ff || ready_b;
   assign req_tready = ready_a;
   assign a_xfer     = a_valid_ff && ready_b;
   assign b_xfer     = b_valid_ff && ready_out;

   // input register
   kind_type                 a_kind_ff;
   logic signed [DATA_W-1:0] a_pv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (ready_a) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && req_tvalid) begin
         a_kind_ff <= kind_type'(req_tuser);
         a_pv_ff   <= req_tdata;
      end
   end

   // loop state
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;

   logic signed [ERR_W-1:0]   err_w;
   logic signed [DERIV_W-1:0] deriv_w;
   logic signed [INTEG_W-1:0] integ_sum_w;
   logic [INTEG_W-1:0]        integ_mag_w;
   logic [LIMIT_W:0]          limit2_w;
   logic                      integ_keep_w;

   always_comb begin
      err_w   = ERR_W'(setpoint_ff) - ERR_W'(a_pv_ff);
      deriv_w = DERIV_W'(err_w) - DERIV_W'(prev_err_ff);
      integ_sum_w = integ_ff + INTEG_W'(err_w) + INTEG_W'(prev_err_ff);
      integ_mag_w = integ_ff[INTEG_W-1] ? INTEG_W'(-integ_ff) : INTEG_W'(integ_ff);
      limit2_w    = {limit_ff, 1'b0};
      // test uses the integral held before this sample
      integ_keep_w = integ_mag_w < INTEG_W'(limit2_w);

      prev_err_in = prev_err_ff;
      integ_in    = integ_ff;
      if (a_xfer) begin
         unique case (a_kind_ff)
            KIND_SAMPLE: begin
               prev_err_in = err_w;
               integ_in    = integ_keep_w ? integ_sum_w : '0;
            end
            KIND_CLEAR_ALL: begin
               prev_err_in = '0;
               integ_in    = '0;
            end
            KIND_CLEAR_INTEG: integ_in = '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
         integ_ff    <= '0;
      end else begin
         prev_err_ff <= prev_err_in;
         integ_ff    <= integ_in;
      end
   end

   // stage b: error terms of one sample
   logic signed [ERR_W-1:0]   b_err_ff;
   logic signed [DERIV_W-1:0] b_deriv_ff;
   logic signed [INTEG_W-1:0] b_integ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (ready_b) begin
         b_valid_ff <= a_valid_ff && (a_kind_ff == KIND_SAMPLE);
      end
   end

   always_ff @(posedge clock) begin
      if (ready_b) begin
         b_err_ff   <= err_w;
         b_deriv_ff <= deriv_w;
         b_integ_ff <= integ_in;
      end
   end

   // stage c: gain products and sum
   logic signed [ERR_W+DATA_W-1:0]   prod_p_w;
   logic signed [DERIV_W+DATA_W-1:0] prod_d_w;
   logic signed [INTEG_W+DATA_W-1:0] prod_i_w;
   logic signed [ACC_W-1:0]          acc_w;

   always_comb begin
      prod_p_w = gain_p_ff * b_err_ff;
      prod_d_w = gain_d_ff * b_deriv_ff;
      prod_i_w = gain_i_ff * b_integ_ff;
      acc_w = (ACC_W'(prod_p_w) <<< 1) + (ACC_W'(prod_d_w) <<< 1) + ACC_W'(prod_i_w);
   end

   logic [DRIVE_W-1:0] drive_ff;
   logic [DERIV_W-1:0] rsp_deriv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready_out) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (b_xfer) begin
         // floor shift by the gain fraction plus the half-unit bit
         drive_ff     <= acc_w[GAIN_FRAC_BITS+1 +: DRIVE_W];
         rsp_deriv_ff <= b_deriv_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-DRIVE_W-DERIV_W){1'b0}}, rsp_deriv_ff, drive_ff};

`ifndef SYNTHESIS
   a_clear_all_zeroes_state: assert property (@(posedge clock) disable iff (reset)
      a_xfer && (a_kind_ff == KIND_CLEAR_ALL) |=> (prev_err_ff == '0) && (integ_ff == '0))
      else $error("clear transfer left loop state nonzero");

   a_integ_bounded: assert property (@(posedge clock) disable iff (reset)
      (integ_ff <= INTEG_W'(INTEG_BOUND)) && (integ_ff >= -INTEG_W'(INTEG_BOUND)))
      else $error("integral outside its reachable range");

   a_stage_b_holds: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !ready_out |=> b_valid_ff && $stable(b_deriv_ff) && $stable(b_err_ff))
      else $error("stage b lost a sample while the output was stalled");

   a_state_only_on_transfer: assert property (@(posedge clock) disable iff (reset)
      !a_xfer |=> $stable(prev_err_ff) && $stable(integ_ff))
      else $error("loop state changed without an item");
`endif

endmodule
